@@ hw/rtl/lidar_cluster_cone_check_top_macros.svh @@
// assertion macros for the lidar cluster cone check block
`ifndef LIDAR_CLUSTER_CONE_CHECK_TOP_MACROS_SVH
`define LIDAR_CLUSTER_CONE_CHECK_TOP_MACROS_SVH
`ifndef SYNTH
`define LCC_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lcc assertion failed");
`define LCC_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("lcc assertion failed");
`else
`define LCC_ASSERT(name, prop)
`define LCC_ASSERT_NEXT(name, pre, post)
`endif
`endif

@@ hw/rtl/lcc_pkg.sv @@
// shared types and constants for the lidar cluster cone check block
package lcc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_COUNT_TOL    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_HEIGHT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CENT_Z   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_SCALE  = 3'd4;

    typedef enum logic [5:0] {
        ST_ACC  = 6'b000001,
        ST_DIV  = 6'b000010,
        ST_SQ   = 6'b000100,
        ST_PROD = 6'b001000,
        ST_CHK  = 6'b010000,
        ST_OUT  = 6'b100000
    } lcc_state_t;

    typedef struct packed {
        logic       accept;
        logic       start;
        logic       div_step;
        logic       sq_step;
        logic [1:0] sq_sel;
        logic       prod;
        logic       check;
        logic       load_out;
    } lcc_cmd_t;

    typedef struct packed {
        logic out_free;
    } lcc_stat_t;

endpackage

@@ hw/rtl/lcc_datapath.sv @@
// accumulators, serial divider, distance, count and shape check, output register
module lcc_datapath
    import lcc_pkg::*;
#(
    parameter int MAX_POINTS = 511,
    parameter int COORD_BITS = 18
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  lcc_cmd_t                     cmd,
    output lcc_stat_t                    stat,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_y,
    input  logic signed [COORD_BITS-1:0] point_z,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_wdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [((3*COORD_BITS+7)/8)*8-1:0] m_tdata,
    output logic                         m_tuser
);

    localparam int CB    = COORD_BITS;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int SUM_W = CB + CNT_W;
    localparam int SQ_W  = 2 * CB;
    localparam int D2_W  = SQ_W + 2;
    localparam int ND_W  = D2_W + CNT_W;
    localparam int DF_W  = (ND_W > 33) ? ND_W : 33;
    localparam int SP_W  = (CB + 1 > 16) ? CB + 1 : 16;
    localparam int ZC_W  = (CB > 18) ? CB : 18;
    localparam int OUT_W = ((3 * CB + 7) / 8) * 8;
    localparam int PAD_W = OUT_W - 3 * CB;

    // configuration
    logic [7:0]         tol_reg;
    logic [15:0]        max_width_reg;
    logic [15:0]        max_height_reg;
    logic signed [17:0] max_cz_reg;
    logic [31:0]        scale_reg;

    // accumulators
    logic signed [SUM_W-1:0] sum_reg  [3];
    logic signed [CB-1:0]    low_reg  [3];
    logic signed [CB-1:0]    high_reg [3];
    logic [CNT_W-1:0]        cnt_reg;

    // divider
    logic [SUM_W-1:0] dq_reg  [3];
    logic [CNT_W-1:0] rem_reg [3];
    logic             neg_reg [3];
    logic [CNT_W-1:0] dn_reg;

    // count check
    logic [D2_W-1:0] d2_reg;
    logic [ND_W-1:0] nd_reg;
    logic [39:0]     ts_reg;
    logic            cone_reg;

    logic             m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;
    logic             m_tuser_reg;

    logic signed [CB-1:0]    pnt      [3];
    logic                    take;
    logic signed [SUM_W-1:0] sum_upd  [3];
    logic [SUM_W-1:0]        sum_mag  [3];
    logic [CNT_W-1:0]        cnt_upd;
    logic [CNT_W:0]          shifted  [3];
    logic [CNT_W+1:0]        trial    [3];
    logic [CB-1:0]           mag      [3];
    logic signed [CB-1:0]    cent     [3];
    logic [CB-1:0]           sq_in;
    logic [SQ_W-1:0]         sq;
    logic [ND_W-1:0]         nd_full;
    logic [39:0]             ts_full;
    logic [DF_W-1:0]         scale_x;
    logic [DF_W-1:0]         nd_x;
    logic [DF_W-1:0]         diff;
    logic                    count_ok;
    logic [CB:0]             span     [3];
    logic                    shape_ok;
    logic signed [ZC_W-1:0]  cz_ext;
    logic signed [ZC_W-1:0]  maxz_ext;

    assign pnt[0] = point_x;
    assign pnt[1] = point_y;
    assign pnt[2] = point_z;
    assign take   = cmd.accept && (cnt_reg != CNT_W'(MAX_POINTS));

    always_comb
    begin
        cnt_upd = take ? cnt_reg + CNT_W'(1) : cnt_reg;
        for (int i = 0; i < 3; i++)
        begin
            sum_upd[i] = take ? sum_reg[i] + SUM_W'(pnt[i]) : sum_reg[i];
            sum_mag[i] = sum_upd[i][SUM_W-1] ? SUM_W'(-sum_upd[i]) : SUM_W'(sum_upd[i]);
            shifted[i] = {rem_reg[i], dq_reg[i][SUM_W-1]};
            trial[i]   = {1'b0, shifted[i]} - {2'b00, dn_reg};
            mag[i]     = dq_reg[i][CB-1:0];
            cent[i]    = neg_reg[i] ? CB'(-$signed(mag[i])) : $signed(mag[i]);
            span[i]    = {high_reg[i][CB-1], high_reg[i]} - {low_reg[i][CB-1], low_reg[i]};
        end
    end

    always_comb
    begin
        case (cmd.sq_sel)
            2'd0:    sq_in = mag[0];
            2'd1:    sq_in = mag[1];
            default: sq_in = mag[2];
        endcase
    end

    assign sq      = sq_in * sq_in;
    assign nd_full = dn_reg * d2_reg;
    assign ts_full = tol_reg * scale_reg;

    assign scale_x  = DF_W'(scale_reg);
    assign nd_x     = DF_W'(nd_reg);
    assign diff     = (scale_x > nd_x) ? scale_x - nd_x : nd_x - scale_x;
    assign count_ok = (diff[DF_W-1:32] == '0) && ({diff[31:0], 8'h00} < ts_reg);

    assign cz_ext   = ZC_W'(cent[2]);
    assign maxz_ext = ZC_W'(max_cz_reg);
    assign shape_ok = (SP_W'(span[0]) < SP_W'(max_width_reg))
                   && (SP_W'(span[1]) < SP_W'(max_width_reg))
                   && (SP_W'(span[2]) < SP_W'(max_height_reg))
                   && (cz_ext < maxz_ext);

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg        <= 8'd128;
            max_width_reg  <= 16'd500;
            max_height_reg <= 16'd400;
            max_cz_reg     <= 18'sd400;
            scale_reg      <= 32'd1976800000;
            cnt_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_COUNT_TOL:   tol_reg        <= cfg_wdata[7:0];
                    REG_MAX_WIDTH:   max_width_reg  <= cfg_wdata[15:0];
                    REG_MAX_HEIGHT:  max_height_reg <= cfg_wdata[15:0];
                    REG_MAX_CENT_Z:  max_cz_reg     <= $signed(cfg_wdata[17:0]);
                    REG_COUNT_SCALE: scale_reg      <= cfg_wdata;
                    default:         ;
                endcase
            end
            if (cmd.start)
            begin
                cnt_reg <= '0;
                for (int i = 0; i < 3; i++)
                begin
                    sum_reg[i] <= '0;
                end
            end
            else
            begin
                cnt_reg <= cnt_upd;
                for (int i = 0; i < 3; i++)
                begin
                    sum_reg[i] <= sum_upd[i];
                end
            end
            if (cmd.load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (take)
            begin
                if (cnt_reg == '0 || pnt[i] < low_reg[i])
                begin
                    low_reg[i] <= pnt[i];
                end
                if (cnt_reg == '0 || pnt[i] > high_reg[i])
                begin
                    high_reg[i] <= pnt[i];
                end
            end
            if (cmd.start)
            begin
                dq_reg[i]  <= sum_mag[i];
                neg_reg[i] <= sum_upd[i][SUM_W-1];
                rem_reg[i] <= '0;
            end
            else if (cmd.div_step)
            begin
                if (!trial[i][CNT_W+1])
                begin
                    rem_reg[i] <= trial[i][CNT_W-1:0];
                    dq_reg[i]  <= {dq_reg[i][SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i] <= shifted[i][CNT_W-1:0];
                    dq_reg[i]  <= {dq_reg[i][SUM_W-2:0], 1'b0};
                end
            end
        end
        if (cmd.start)
        begin
            dn_reg <= cnt_upd;
            d2_reg <= '0;
        end
        else if (cmd.sq_step)
        begin
            d2_reg <= d2_reg + D2_W'(sq);
        end
        if (cmd.prod)
        begin
            nd_reg <= nd_full;
            ts_reg <= ts_full;
        end
        if (cmd.check)
        begin
            cone_reg <= shape_ok && count_ok;
        end
        if (cmd.load_out)
        begin
            m_tdata_reg <= {{PAD_W{1'b0}}, cent[2], cent[1], cent[0]};
            m_tuser_reg <= cone_reg;
        end
    end

    assign stat.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_tdata_reg;
    assign m_tuser       = m_tuser_reg;

endmodule

@@ hw/rtl/lcc_ctrl.sv @@
// sequencer for accumulation, division, distance and verdict steps
module lcc_ctrl
    import lcc_pkg::*;
#(
    parameter int MAX_POINTS = 511,
    parameter int COORD_BITS = 18
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    input  logic      s_tlast,
    output logic      s_tready,
    input  lcc_stat_t stat,
    output lcc_cmd_t  cmd
);

    localparam int SUM_W = COORD_BITS + $clog2(MAX_POINTS + 1);
    localparam int DC_W  = $clog2(SUM_W);

    lcc_state_t      state_reg;
    lcc_state_t      state_next;
    logic [DC_W-1:0] step_reg;
    logic [DC_W-1:0] step_next;

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.sq_sel   = step_reg[1:0];
        unique case (state_reg)
            ST_ACC:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid && s_tlast)
                begin
                    cmd.start  = 1'b1;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == DC_W'(SUM_W - 1))
                begin
                    step_next  = '0;
                    state_next = ST_SQ;
                end
                else
                begin
                    step_next = step_reg + DC_W'(1);
                end
            end
            ST_SQ:
            begin
                cmd.sq_step = 1'b1;
                if (step_reg == DC_W'(2))
                begin
                    state_next = ST_PROD;
                end
                else
                begin
                    step_next = step_reg + DC_W'(1);
                end
            end
            ST_PROD:
            begin
                cmd.prod   = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                cmd.check  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_ACC;
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACC;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

@@ hw/rtl/lidar_cluster_cone_check_top.sv @@
// lidar cluster cone check: centroid and cone verdict for each point cluster
// Points are taken one per cycle while a cluster accumulates. The point that
// carries tlast starts the closing work, during which no point is taken: a
// bit-serial divider runs, then the three centroid coordinates are squared
// and summed, then come a product step, a verdict step and the load of the
// output register, which waits until that register is free. The result register
// lets the next cluster accumulate while a result still waits to be taken.
`include "lidar_cluster_cone_check_top_macros.svh"
module lidar_cluster_cone_check_top
    import lcc_pkg::*;
#(
    parameter int MAX_POINTS = 511,
    parameter int COORD_BITS = 18
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // point_x, point_y, point_z, zero pad
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]     s_tdata,
    // last_point
    input  logic                                  s_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // centroid_x, centroid_y, centroid_z, zero pad
    output logic [((3*COORD_BITS+7)/8)*8-1:0]     m_tdata,
    // is_cone
    output logic                                  m_tuser,
    input  logic                                  cfg_we,
    input  logic [CFG_IDX_W-1:0]                  cfg_index,
    input  logic [CFG_DATA_W-1:0]                 cfg_wdata
);

    lcc_cmd_t  cmd;
    lcc_stat_t stat;

    lcc_ctrl #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lcc_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .point_x   ($signed(s_tdata[COORD_BITS-1:0])),
        .point_y   ($signed(s_tdata[2*COORD_BITS-1:COORD_BITS])),
        .point_z   ($signed(s_tdata[3*COORD_BITS-1:2*COORD_BITS])),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    `LCC_ASSERT_NEXT(a_busy_after_last, s_tvalid && s_tready && s_tlast, !s_tready)
    `LCC_ASSERT(a_no_overwrite, cmd.load_out |-> (!m_tvalid || m_tready))
    `LCC_ASSERT(a_div_blocks_input, cmd.div_step |-> !s_tready)

endmodule
